@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication: post must hold in the cycle after pre.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/cav_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cav_pkg;

	localparam int ITERATIONS_DEF = 24;
	localparam int DATA_WIDTH_DEF = 32;

	// width of the input coordinate ports and of the angle port
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 32;
	// angle accumulator: pi plus the whole table sum needs 33 signed bits
	localparam int ACC_W = 33;
	localparam int TABLE_DEPTH = 32;

	localparam logic signed [ACC_W-1:0] ANGLE_PI = 33'sd1686629713;
	localparam logic signed [ACC_W-1:0] ANGLE_NEG_PI = -33'sd1686629713;

	// round(atan(2^-i) * 2^29)
	localparam logic signed [ACC_W-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
		33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579,
		33'sd33510843, 33'sd16771758, 33'sd8387925, 33'sd4194219,
		33'sd2097141, 33'sd1048575, 33'sd524288, 33'sd262144,
		33'sd131072, 33'sd65536, 33'sd32768, 33'sd16384,
		33'sd8192, 33'sd4096, 33'sd2048, 33'sd1024,
		33'sd512, 33'sd256, 33'sd128, 33'sd64,
		33'sd32, 33'sd16, 33'sd8, 33'sd4,
		33'sd2, 33'sd1, 33'sd0, 33'sd0
	};

endpackage

`default_nettype wire

@@ hw/rtl/cav_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cav_prep #(
	parameter int DATA_WIDTH = cav_pkg::DATA_WIDTH_DEF,
	parameter int PATH_W     = cav_pkg::DATA_WIDTH_DEF + 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  logic signed [cav_pkg::COORD_W-1:0]  y_coord,
	input  logic signed [cav_pkg::COORD_W-1:0]  x_coord,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output logic signed [PATH_W-1:0]            y_dn,
	output logic signed [PATH_W-1:0]            x_dn,
	output logic signed [cav_pkg::ACC_W-1:0]    acc_dn,
	output logic                                zero_dn
);
	import cav_pkg::*;

	logic                     valid_q;
	logic signed [PATH_W-1:0] y_q, x_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     zero_q;

	logic [DATA_WIDTH-1:0]    y_raw, x_raw;
	logic signed [PATH_W-1:0] y_ext, x_ext, y_fold, x_fold;
	logic signed [ACC_W-1:0]  acc_init;
	logic                     left_half, load;

	// keep the low DATA_WIDTH bits and sign-extend them into the wide path
	assign y_raw = y_coord[DATA_WIDTH-1:0];
	assign x_raw = x_coord[DATA_WIDTH-1:0];
	assign y_ext = {{(PATH_W-DATA_WIDTH){y_raw[DATA_WIDTH-1]}}, y_raw};
	assign x_ext = {{(PATH_W-DATA_WIDTH){x_raw[DATA_WIDTH-1]}}, x_raw};

	assign left_half = x_ext[PATH_W-1];

	always_comb begin
		y_fold   = left_half ? -y_ext : y_ext;
		x_fold   = left_half ? -x_ext : x_ext;
		acc_init = '0;
		if (left_half) begin
			// start at -pi when the folded y is strictly positive
			acc_init = (!y_fold[PATH_W-1] && (y_fold != '0)) ? ANGLE_NEG_PI : ANGLE_PI;
		end
	end

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			y_q    <= y_fold;
			x_q    <= x_fold;
			acc_q  <= acc_init;
			zero_q <= (y_raw == '0) && (x_raw == '0);
		end
	end

	assign dn_valid = valid_q;
	assign y_dn     = y_q;
	assign x_dn     = x_q;
	assign acc_dn   = acc_q;
	assign zero_dn  = zero_q;

endmodule

`default_nettype wire

@@ hw/rtl/cav_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cav_cell #(
	parameter int PATH_W = cav_pkg::DATA_WIDTH_DEF + 2,
	parameter int SHIFT  = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             up_valid,
	output logic                             up_ready,
	input  logic signed [PATH_W-1:0]         y_up,
	input  logic signed [PATH_W-1:0]         x_up,
	input  logic signed [cav_pkg::ACC_W-1:0] acc_up,
	input  logic                             zero_up,
	output logic                             dn_valid,
	input  logic                             dn_ready,
	output logic signed [PATH_W-1:0]         y_dn,
	output logic signed [PATH_W-1:0]         x_dn,
	output logic signed [cav_pkg::ACC_W-1:0] acc_dn,
	output logic                             zero_dn
);
	import cav_pkg::*;

	localparam logic signed [ACC_W-1:0] STEP_ANGLE = ATAN_TABLE[SHIFT];

	logic                     valid_q;
	logic signed [PATH_W-1:0] y_q, x_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     zero_q;

	logic signed [PATH_W-1:0] dx, dy, y_next, x_next;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     load;

	assign dx = x_up >>> SHIFT;
	assign dy = y_up >>> SHIFT;

	// rotate toward the x axis, direction set by the sign of y
	always_comb begin
		if (y_up[PATH_W-1]) begin
			y_next   = y_up + dx;
			x_next   = x_up - dy;
			acc_next = acc_up - STEP_ANGLE;
		end else begin
			y_next   = y_up - dx;
			x_next   = x_up + dy;
			acc_next = acc_up + STEP_ANGLE;
		end
	end

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			y_q    <= y_next;
			x_q    <= x_next;
			acc_q  <= acc_next;
			zero_q <= zero_up;
		end
	end

	assign dn_valid = valid_q;
	assign y_dn     = y_q;
	assign x_dn     = x_q;
	assign acc_dn   = acc_q;
	assign zero_dn  = zero_q;

endmodule

`default_nettype wire

@@ hw/rtl/cav_clamp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cav_clamp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic signed [cav_pkg::ACC_W-1:0]   acc_up,
	input  logic                               zero_up,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic signed [cav_pkg::ANGLE_W-1:0] angle
);
	import cav_pkg::*;

	logic                      valid_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [ACC_W-1:0]   acc_sat;
	logic                      load;

	// hold the residual inside [-pi, pi]; a zero vector gives zero
	always_comb begin
		if (zero_up) begin
			acc_sat = '0;
		end else if (acc_up > ANGLE_PI) begin
			acc_sat = ANGLE_PI;
		end else if (acc_up < ANGLE_NEG_PI) begin
			acc_sat = ANGLE_NEG_PI;
		end else begin
			acc_sat = acc_up;
		end
	end

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			angle_q <= acc_sat[ANGLE_W-1:0];
		end
	end

	assign dn_valid = valid_q;
	assign angle    = angle_q;

endmodule

`default_nettype wire

@@ hw/rtl/cordic_atan2_vectoring_unit.sv @@
// Two-argument arctangent, CORDIC in vectoring mode.
// Request channel: req_valid / req_ready carry a signed (y_coord, x_coord)
// pair; only the low DATA_WIDTH bits of each are used.
// Result channel: res_valid / res_ready carry angle = atan2(y, x) in radians,
// signed with 29 fraction bits, within +-pi. A zero vector gives 0.
// Stages from request transfer to result valid: one fold stage, one cell per
// micro-rotation, one clamp/output register.
// Throughput: one vector per cycle while the receiver takes results; each stage
// is a register with its own valid bit, so the fold register, the ITERATIONS cells and the clamp set the depth.
// Results come out in request order, one per request.
// Reset clears every stage valid bit; the pipeline is then empty and
// req_ready is high.
// When the receiver stalls, the result is held in the output register and
// earlier stages fill up; req_ready drops only once every stage holds a vector.
`timescale 1ns / 1ps
`default_nettype none

module cordic_atan2_vectoring_unit #(
	parameter int ITERATIONS = cav_pkg::ITERATIONS_DEF,
	parameter int DATA_WIDTH = cav_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic signed [cav_pkg::COORD_W-1:0] y_coord,
	input  logic signed [cav_pkg::COORD_W-1:0] x_coord,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [cav_pkg::ANGLE_W-1:0] angle
);
	import cav_pkg::*;
	`include "assert_macros.svh"

	localparam int PATH_W = DATA_WIDTH + 2;

	logic                     stage_valid [ITERATIONS+1];
	logic                     stage_ready [ITERATIONS+1];
	logic signed [PATH_W-1:0] stage_y     [ITERATIONS+1];
	logic signed [PATH_W-1:0] stage_x     [ITERATIONS+1];
	logic signed [ACC_W-1:0]  stage_acc   [ITERATIONS+1];
	logic                     stage_zero  [ITERATIONS+1];
	logic                     clamp_ready;
	logic [ITERATIONS:0]      valid_vec;
	logic                     pipe_full_stalled;
	logic                     angle_in_range;

	cav_prep #(
		.DATA_WIDTH(DATA_WIDTH),
		.PATH_W    (PATH_W)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(req_valid),
		.up_ready(req_ready),
		.y_coord (y_coord),
		.x_coord (x_coord),
		.dn_valid(stage_valid[0]),
		.dn_ready(stage_ready[0]),
		.y_dn    (stage_y[0]),
		.x_dn    (stage_x[0]),
		.acc_dn  (stage_acc[0]),
		.zero_dn (stage_zero[0])
	);

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		cav_cell #(
			.PATH_W(PATH_W),
			.SHIFT (k % TABLE_DEPTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(stage_valid[k]),
			.up_ready(stage_ready[k]),
			.y_up    (stage_y[k]),
			.x_up    (stage_x[k]),
			.acc_up  (stage_acc[k]),
			.zero_up (stage_zero[k]),
			.dn_valid(stage_valid[k+1]),
			.dn_ready(stage_ready[k+1]),
			.y_dn    (stage_y[k+1]),
			.x_dn    (stage_x[k+1]),
			.acc_dn  (stage_acc[k+1]),
			.zero_dn (stage_zero[k+1])
		);
	end

	assign stage_ready[ITERATIONS] = clamp_ready;

	cav_clamp u_clamp (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(stage_valid[ITERATIONS]),
		.up_ready(clamp_ready),
		.acc_up  (stage_acc[ITERATIONS]),
		.zero_up (stage_zero[ITERATIONS]),
		.dn_valid(res_valid),
		.dn_ready(res_ready),
		.angle   (angle)
	);

	for (genvar k = 0; k <= ITERATIONS; k++) begin : g_vvec
		assign valid_vec[k] = stage_valid[k];
	end

	assign pipe_full_stalled = (&valid_vec) && res_valid && !res_ready;
	assign angle_in_range    = (angle <= $signed(ANGLE_PI[ANGLE_W-1:0]))
		&& (angle >= $signed(ANGLE_NEG_PI[ANGLE_W-1:0]));

	// a dropped req_ready means the whole chain is full and the output is stalled
	`ASSERT_CLK(a_full_when_blocked, !req_ready |-> pipe_full_stalled, "req_ready low with a bubble")
	// x only grows through the rotations and starts non-negative
	`ASSERT_CLK(a_x_nonneg, stage_valid[ITERATIONS] |-> !stage_x[ITERATIONS][PATH_W-1], "negative x")
	`ASSERT_CLK(a_angle_range, res_valid |-> angle_in_range, "angle outside +-pi")
	// a result that was not taken stays valid and unchanged through the next edge
	`ASSERT_NEXT(a_clamp_hold, res_valid && !res_ready, res_valid && $stable(angle), "result changed")

endmodule

`default_nettype wire

@@ tb/tb_cordic_atan2_vectoring_unit.sv @@
`timescale 1ns / 1ps

module tb_cordic_atan2_vectoring_unit;

	localparam int CLK_PERIOD = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_VECTORS = 550;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = cav_pkg::ITERATIONS_DEF + 10;
	localparam longint PI_FIX = 64'sd1686629713;

	// atan(2^-i) in radians, 29 fraction bits
	localparam longint ARCTAN_STEP [32] = '{
		421657428, 248918915, 131521918, 66762579,
		33510843, 16771758, 8387925, 4194219,
		2097141, 1048575, 524288, 262144,
		131072, 65536, 32768, 16384,
		8192, 4096, 2048, 1024,
		512, 256, 128, 64,
		32, 16, 8, 4,
		2, 1, 0, 0
	};

	localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [cav_pkg::COORD_W-1:0] y;
		logic signed [cav_pkg::COORD_W-1:0] x;
		logic signed [cav_pkg::ANGLE_W-1:0] angle;
	} angle_entry_t;

	class angle_scoreboard;
		angle_entry_t pending_q[$];
		int mismatches = 0;
		int checked = 0;
		int vectors = 0;
		int left_half = 0;
		int zero_vectors = 0;
		int clamped = 0;

		// CORDIC vectoring: fold into the right half plane, then rotate y to zero
		function automatic logic signed [cav_pkg::ANGLE_W-1:0] predict_angle(
				logic signed [cav_pkg::COORD_W-1:0] y_in,
				logic signed [cav_pkg::COORD_W-1:0] x_in);
			longint vy;
			longint vx;
			longint acc;
			longint dx;
			longint dy;
			vy = longint'(y_in);
			vx = longint'(x_in);
			acc = 0;
			if (vx == 0 && vy == 0) begin
				zero_vectors++;
				return '0;
			end
			if (vx < 0) begin
				vx = -vx;
				vy = -vy;
				acc = PI_FIX;
				left_half++;
			end
			if (vy > 0)
				acc = -acc;
			for (int k = 0; k < cav_pkg::ITERATIONS_DEF; k++) begin
				dx = vx >>> (k & 31);
				dy = vy >>> (k & 31);
				if (vy < 0) begin
					vy = vy + dx;
					vx = vx - dy;
					acc = acc - ARCTAN_STEP[k & 31];
				end else begin
					vy = vy - dx;
					vx = vx + dy;
					acc = acc + ARCTAN_STEP[k & 31];
				end
			end
			if (acc > PI_FIX || acc < -PI_FIX)
				clamped++;
			if (acc > PI_FIX)
				acc = PI_FIX;
			if (acc < -PI_FIX)
				acc = -PI_FIX;
			return acc[cav_pkg::ANGLE_W-1:0];
		endfunction

		function void note_input(logic signed [cav_pkg::COORD_W-1:0] y_in,
				logic signed [cav_pkg::COORD_W-1:0] x_in);
			angle_entry_t e;
			e.y = y_in;
			e.x = x_in;
			e.angle = predict_angle(y_in, x_in);
			vectors++;
			pending_q.push_back(e);
		endfunction

		function void check_result(logic signed [cav_pkg::ANGLE_W-1:0] got);
			angle_entry_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				$display("%0t unexpected angle transfer: expected none, actual %0d",
					$time, got);
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (got !== e.angle) begin
				mismatches++;
				$display("%0t angle mismatch (y=%0d x=%0d): expected %0d, actual %0d",
					$time, e.y, e.x, e.angle, got);
			end
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic signed [cav_pkg::COORD_W-1:0] y_coord;
	logic signed [cav_pkg::COORD_W-1:0] x_coord;
	logic res_valid;
	logic res_ready;
	logic signed [cav_pkg::ANGLE_W-1:0] angle;

	angle_scoreboard sb;
	int snd_idle_pct;
	int rcv_idle_pct;
	bit hold_request;
	int cycle_count;
	int input_stall_cycles;

	cordic_atan2_vectoring_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.y_coord(y_coord),
		.x_coord(x_coord),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.angle(angle)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d angles outstanding",
				$time, cycle_count, sb.outstanding());
			$display("== FAIL ==");
			$finish;
		end
	end

	// sample both channels at the edge where a transfer happens
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_input(y_coord, x_coord);
			if (req_valid && !req_ready)
				input_stall_cycles++;
			if (res_valid && res_ready)
				sb.check_result(angle);
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	task automatic send_vector(logic signed [31:0] y_val, logic signed [31:0] x_val);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		y_coord <= y_val;
		x_coord <= x_val;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic send_random_vector();
		logic signed [31:0] y_val;
		logic signed [31:0] x_val;
		int sel;
		y_val = $urandom;
		x_val = $urandom;
		sel = $urandom_range(0, 9);
		case (sel)
			4, 5: begin
				y_val = $signed($urandom_range(0, 2000)) - 1000;
				x_val = $signed($urandom_range(0, 2000)) - 1000;
			end
			6: begin
				if ($urandom_range(0, 1))
					y_val = '0;
				else
					x_val = '0;
			end
			7: begin
				y_val = ($urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 15)
					: COORD_MIN + $urandom_range(0, 15));
				x_val = ($urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 15)
					: COORD_MIN + $urandom_range(0, 15));
			end
			8: begin
				// left half plane close to the negative x axis: residual can run past pi
				y_val = $signed($urandom_range(0, 4)) - 2;
				x_val = -$signed({1'b0, $urandom_range(1, 32'h7fff_ffff)});
			end
			9: begin
				x_val = $urandom;
				y_val = $urandom_range(0, 1) ? x_val : -x_val;
			end
			default: ;
		endcase
		send_vector(y_val, x_val);
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		input_stall_cycles = 0;
		hold_request = 1'b0;
		snd_idle_pct = 28;
		rcv_idle_pct = 83;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		y_coord <= '0;
		x_coord <= '0;
		res_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axes, diagonals, extremes and the left-half-plane start cases
		send_vector(0, 0);
		send_vector(0, 1);
		send_vector(1, 0);
		send_vector(-1, 0);
		send_vector(0, -1);
		send_vector(0, -7);
		send_vector(1, 1);
		send_vector(-1, -1);
		send_vector(1, -1);
		send_vector(-1, 1);
		send_vector(-5, -7);
		send_vector(5, -7);
		send_vector(COORD_MAX, COORD_MAX);
		send_vector(COORD_MIN, COORD_MIN);
		send_vector(COORD_MIN, 0);
		send_vector(0, COORD_MIN);
		send_vector(COORD_MAX, COORD_MIN);
		send_vector(COORD_MIN, COORD_MAX);
		send_vector(COORD_MIN, -1);
		send_vector(COORD_MAX, -1);
		send_vector(1, COORD_MIN);
		send_vector(-1, COORD_MIN);
		send_vector(0, COORD_MAX);
		send_vector(COORD_MAX, 0);

		for (int i = 0; i < RANDOM_VECTORS; i++) begin
			if (i == RANDOM_VECTORS / 3) begin
				snd_idle_pct = 83;
				rcv_idle_pct = 28;
			end
			if (i == 2 * RANDOM_VECTORS / 3) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
				// block the result side while requests keep coming, to fill the pipe
				hold_request = 1'b1;
			end
			if (i == 2 * RANDOM_VECTORS / 3 + 60) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			send_random_vector();
		end
		req_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d of %0d vectors: %0d zero, %0d left half plane, %0d clamped at pi.",
			sb.checked, sb.vectors, sb.zero_vectors, sb.left_half, sb.clamped);
		$display("Request side was stalled for %0d cycles under result back-pressure.",
			input_stall_cycles);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d angles never arrived", sb.mismatches,
				sb.outstanding());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
